// ===== rtl/tpi_pkg.sv =====
// Shared widths, types and helpers for the three-plane intersection pipeline.
package tpi_pkg;

   localparam int COEF_FRAC_BITS = 16;

   localparam int FW   = 32;
   localparam int OW   = FW + 1;
   localparam int PW   = 2 * OW;
   localparam int MW   = PW + 1;
   localparam int ML   = 34;
   localparam int MH   = MW - ML;
   localparam int LW   = ML + 1 + OW;
   localparam int HW   = MH + OW;
   localparam int TW   = MW + OW;
   localparam int DW   = 98;
   localparam int QB   = 34;
   localparam int RW   = DW + QB + 2;
   localparam int CMPW = DW + 32;
   localparam int LSH  = (3 * COEF_FRAC_BITS >= 32) ? 0 : 32 - 3 * COEF_FRAC_BITS;
   localparam int RSH  = (3 * COEF_FRAC_BITS >= 32) ? 3 * COEF_FRAC_BITS - 32 : 0;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SINGULAR  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      logic                 valid;
      logic [8:0][OW-1:0]   m;
      logic [2:0][OW-1:0]   r;
   } coef_type;

   typedef struct packed {
      logic                 valid;
      logic [DW-1:0]        det;
      logic [2:0][DW-1:0]   num;
   } num_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [QB-1:0] quo;
      logic          neg;
      logic          ovf;
   } lane_type;

   typedef struct packed {
      logic               valid;
      logic               singular;
      logic [DW:0]        dvs;
      lane_type [2:0]     lane;
   } div_type;

   function automatic int col_p(input int k);
      return (k == 0) ? 1 : 0;
   endfunction

   function automatic int col_q(input int k);
      return (k == 2) ? 1 : 2;
   endfunction

   function automatic int row_j(input int i);
      return (i == 0) ? 1 : 0;
   endfunction

   function automatic int row_l(input int i);
      return (i == 2) ? 1 : 2;
   endfunction

endpackage

// ===== rtl/tpi_req_if.sv =====
// Request channel carrying one plane triple per item.
interface tpi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] p1_a;
   logic signed [31:0] p1_b;
   logic signed [31:0] p1_c;
   logic signed [31:0] p1_d;
   logic signed [31:0] p2_a;
   logic signed [31:0] p2_b;
   logic signed [31:0] p2_c;
   logic signed [31:0] p2_d;
   logic signed [31:0] p3_a;
   logic signed [31:0] p3_b;
   logic signed [31:0] p3_c;
   logic signed [31:0] p3_d;

   modport source (output valid, p1_a, p1_b, p1_c, p1_d, p2_a, p2_b, p2_c, p2_d,
                   p3_a, p3_b, p3_c, p3_d, input ready);
   modport sink (input valid, p1_a, p1_b, p1_c, p1_d, p2_a, p2_b, p2_c, p2_d,
                 p3_a, p3_b, p3_c, p3_d, output ready);
endinterface

// ===== rtl/tpi_rsp_if.sv =====
// Response channel carrying the intersection point and status per item.
interface tpi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic [1:0]         status;

   modport source (output valid, point_x, point_y, point_z, status, input ready);
   modport sink (input valid, point_x, point_y, point_z, status, output ready);
endinterface

// ===== rtl/tpi_det_pipe.sv =====
// Six-stage pipeline computing the determinant and the three Cramer numerators.
module tpi_det_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  tpi_pkg::coef_type  coef_in,
   output tpi_pkg::num_type   num_out
);

   logic [5:0]                                  valid_ff;
   logic [8:0][tpi_pkg::OW-1:0]                 m_ff;
   logic [2:0][tpi_pkg::OW-1:0]                 r_ff;
   logic [3:0][2:0][tpi_pkg::OW-1:0]            elem2_ff, elem2_in, elem3_ff;
   logic [2:0][2:0][1:0][tpi_pkg::PW-1:0]       prod_ff, prod_in;
   logic [2:0][2:0][tpi_pkg::MW-1:0]            minor_ff, minor_in;
   logic [3:0][2:0][tpi_pkg::LW-1:0]            lo_ff, lo_in;
   logic [3:0][2:0][tpi_pkg::HW-1:0]            hi_ff, hi_in;
   logic [3:0][2:0][tpi_pkg::TW-1:0]            term_ff, term_in;
   logic [3:0][tpi_pkg::DW-1:0]                 sum_ff, sum_in;

   always_comb begin
      logic signed [tpi_pkg::PW-1:0] pa;
      logic signed [tpi_pkg::PW-1:0] pb;
      logic signed [tpi_pkg::MW-1:0] ma;
      logic signed [tpi_pkg::MW-1:0] mb;
      logic signed [tpi_pkg::LW-1:0] lo;
      logic signed [tpi_pkg::HW-1:0] hi;
      logic signed [tpi_pkg::TW-1:0] th;
      logic signed [tpi_pkg::TW-1:0] tl;
      logic signed [tpi_pkg::TW-1:0] acc;
      int k;
      for (int kk = 0; kk < 3; kk++) begin
         for (int i = 0; i < 3; i++) begin
            pa = $signed(m_ff[tpi_pkg::row_j(i) * 3 + tpi_pkg::col_p(kk)]) *
                 $signed(m_ff[tpi_pkg::row_l(i) * 3 + tpi_pkg::col_q(kk)]);
            pb = $signed(m_ff[tpi_pkg::row_j(i) * 3 + tpi_pkg::col_q(kk)]) *
                 $signed(m_ff[tpi_pkg::row_l(i) * 3 + tpi_pkg::col_p(kk)]);
            prod_in[kk][i][0] = pa;
            prod_in[kk][i][1] = pb;
            ma = $signed(prod_ff[kk][i][0]);
            mb = $signed(prod_ff[kk][i][1]);
            minor_in[kk][i] = ma - mb;
         end
      end
      for (int i = 0; i < 3; i++) begin
         elem2_in[0][i] = m_ff[i * 3];
         for (int ln = 1; ln < 4; ln++) begin
            elem2_in[ln][i] = r_ff[i];
         end
      end
      for (int ln = 0; ln < 4; ln++) begin
         k = (ln == 0) ? 0 : ln - 1;
         acc = '0;
         for (int i = 0; i < 3; i++) begin
            lo = $signed({1'b0, minor_ff[k][i][tpi_pkg::ML-1:0]}) * $signed(elem3_ff[ln][i]);
            hi = $signed(minor_ff[k][i][tpi_pkg::MW-1:tpi_pkg::ML]) * $signed(elem3_ff[ln][i]);
            lo_in[ln][i] = lo;
            hi_in[ln][i] = hi;
            th = $signed(hi_ff[ln][i]);
            tl = $signed(lo_ff[ln][i]);
            term_in[ln][i] = (th <<< tpi_pkg::ML) + tl;
            if (((i + k) & 1) == 1) begin
               acc = acc - $signed(term_ff[ln][i]);
            end else begin
               acc = acc + $signed(term_ff[ln][i]);
            end
         end
         sum_in[ln] = acc[tpi_pkg::DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[4:0], coef_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m_ff     <= coef_in.m;
         r_ff     <= coef_in.r;
         prod_ff  <= prod_in;
         elem2_ff <= elem2_in;
         minor_ff <= minor_in;
         elem3_ff <= elem2_ff;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         term_ff  <= term_in;
         sum_ff   <= sum_in;
      end
   end

   assign num_out.valid = valid_ff[5];
   assign num_out.det   = sum_ff[0];
   assign num_out.num   = {sum_ff[3], sum_ff[2], sum_ff[1]};

endmodule

// ===== rtl/tpi_setup.sv =====
// Three stages that take magnitudes, test for a singular system and set up division.
module tpi_setup (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [31:0]       tolerance,
   input  tpi_pkg::num_type  num_in,
   output tpi_pkg::div_type  div_out
);

   logic                              a_valid_ff, a_sing_ff, a_sing_in;
   logic [tpi_pkg::DW-1:0]            a_ad_ff, a_ad_in;
   logic [2:0][tpi_pkg::DW-1:0]       a_an_ff, a_an_in;
   logic [2:0]                        a_neg_ff, a_neg_in;
   logic                              b_valid_ff, b_sing_ff;
   logic [tpi_pkg::DW:0]              b_d2_ff, b_d2_in;
   logic [2:0][tpi_pkg::RW-1:0]       b_n2_ff, b_n2_in;
   logic [2:0]                        b_neg_ff;
   tpi_pkg::div_type                  div_ff, div_in;

   always_comb begin
      logic [tpi_pkg::DW-1:0]   det;
      logic [tpi_pkg::DW-1:0]   num;
      logic [tpi_pkg::CMPW-1:0] lhs;
      logic [tpi_pkg::CMPW-1:0] rhs;
      logic [tpi_pkg::RW-1:0]   lim;
      det = num_in.det;
      a_ad_in = det[tpi_pkg::DW-1] ? (tpi_pkg::DW'(0) - det) : det;
      for (int k = 0; k < 3; k++) begin
         num = num_in.num[k];
         a_an_in[k]  = num[tpi_pkg::DW-1] ? (tpi_pkg::DW'(0) - num) : num;
         a_neg_in[k] = num[tpi_pkg::DW-1] ^ det[tpi_pkg::DW-1];
      end
      lhs = tpi_pkg::CMPW'(a_ad_in) << tpi_pkg::LSH;
      rhs = tpi_pkg::CMPW'(tolerance) << tpi_pkg::RSH;
      a_sing_in = (lhs <= rhs);

      b_d2_in = {a_ad_ff, 1'b0};
      for (int k = 0; k < 3; k++) begin
         b_n2_in[k] = (tpi_pkg::RW'(a_an_ff[k]) << (tpi_pkg::COEF_FRAC_BITS + 1)) +
                      tpi_pkg::RW'(a_ad_ff);
      end

      lim = tpi_pkg::RW'(b_d2_ff) << tpi_pkg::QB;
      div_in.valid    = b_valid_ff;
      div_in.singular = b_sing_ff;
      div_in.dvs      = b_d2_ff;
      for (int k = 0; k < 3; k++) begin
         div_in.lane[k].rem = b_n2_ff[k];
         div_in.lane[k].quo = '0;
         div_in.lane[k].neg = b_neg_ff[k];
         div_in.lane[k].ovf = (b_n2_ff[k] >= lim);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         div_ff.valid <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= num_in.valid;
         b_valid_ff <= a_valid_ff;
         div_ff     <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_sing_ff <= a_sing_in;
         a_ad_ff   <= a_ad_in;
         a_an_ff   <= a_an_in;
         a_neg_ff  <= a_neg_in;
         b_sing_ff <= a_sing_ff;
         b_d2_ff   <= b_d2_in;
         b_n2_ff   <= b_n2_in;
         b_neg_ff  <= a_neg_ff;
      end
   end

   assign div_out = div_ff;

endmodule

// ===== rtl/tpi_divider.sv =====
// Restoring divider, one quotient bit per pipeline stage for all three coordinates.
module tpi_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  tpi_pkg::div_type  div_in,
   output tpi_pkg::div_type  div_out
);

   tpi_pkg::div_type stage_ff [tpi_pkg::QB];
   tpi_pkg::div_type stage_in [tpi_pkg::QB];

   always_comb begin
      tpi_pkg::div_type       src;
      logic [tpi_pkg::RW-1:0] cand;
      int                     b;
      for (int s = 0; s < tpi_pkg::QB; s++) begin
         src = (s == 0) ? div_in : stage_ff[(s == 0) ? 0 : s - 1];
         b = tpi_pkg::QB - 1 - s;
         stage_in[s] = src;
         cand = tpi_pkg::RW'(src.dvs) << b;
         for (int k = 0; k < 3; k++) begin
            if (src.lane[k].rem >= cand) begin
               stage_in[s].lane[k].rem    = src.lane[k].rem - cand;
               stage_in[s].lane[k].quo[b] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < tpi_pkg::QB; s++) begin
            stage_ff[s].valid <= 1'b0;
         end
      end else if (enable) begin
         for (int s = 0; s < tpi_pkg::QB; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign div_out = stage_ff[tpi_pkg::QB-1];

endmodule

// ===== rtl/three_plane_point_intersect_unit.sv =====
// Top level of the three-plane intersection point solver.
// An accepted item passes six determinant stages, three setup stages, 34 divider
// stages and the output register on its way to its result.
// Throughput is one item per cycle; the whole pipeline holds while a result waits.
// Synchronous reset empties the pipeline and sets the tolerance register to 1.
module three_plane_point_intersect_unit (
   input  logic              clock,
   input  logic              reset,
   tpi_req_if.sink           req_chan,
   tpi_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   logic                   enable;
   logic [31:0]            tol_ff;
   tpi_pkg::coef_type      coef;
   tpi_pkg::num_type       num;
   tpi_pkg::div_type       setup_div, div_done;
   logic                   rsp_valid_ff;
   logic [2:0][31:0]       point_ff, point_in;
   tpi_pkg::status_type    status_ff, status_in;

   assign enable         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 32'd1;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   assign coef.valid = req_chan.valid;
   assign coef.m = {{req_chan.p3_c[31], req_chan.p3_c}, {req_chan.p3_b[31], req_chan.p3_b},
                    {req_chan.p3_a[31], req_chan.p3_a}, {req_chan.p2_c[31], req_chan.p2_c},
                    {req_chan.p2_b[31], req_chan.p2_b}, {req_chan.p2_a[31], req_chan.p2_a},
                    {req_chan.p1_c[31], req_chan.p1_c}, {req_chan.p1_b[31], req_chan.p1_b},
                    {req_chan.p1_a[31], req_chan.p1_a}};
   assign coef.r = {tpi_pkg::OW'(0) - {req_chan.p3_d[31], req_chan.p3_d},
                    tpi_pkg::OW'(0) - {req_chan.p2_d[31], req_chan.p2_d},
                    tpi_pkg::OW'(0) - {req_chan.p1_d[31], req_chan.p1_d}};

   tpi_det_pipe u_det (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .coef_in (coef),
      .num_out (num)
   );

   tpi_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .tolerance (tol_ff),
      .num_in    (num),
      .div_out   (setup_div)
   );

   tpi_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .div_in  (setup_div),
      .div_out (div_done)
   );

   always_comb begin
      logic [tpi_pkg::QB-1:0] q;
      logic                   sat;
      sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
         q = div_done.lane[k].quo;
         if (div_done.lane[k].neg) begin
            if (div_done.lane[k].ovf || q > tpi_pkg::QB'(33'h080000000)) begin
               point_in[k] = 32'h80000000;
               sat = 1'b1;
            end else begin
               point_in[k] = 32'd0 - q[31:0];
            end
         end else begin
            if (div_done.lane[k].ovf || q > tpi_pkg::QB'(33'h07FFFFFFF)) begin
               point_in[k] = 32'h7FFFFFFF;
               sat = 1'b1;
            end else begin
               point_in[k] = q[31:0];
            end
         end
      end
      if (div_done.singular) begin
         point_in  = '0;
         status_in = tpi_pkg::STATUS_SINGULAR;
      end else if (sat) begin
         status_in = tpi_pkg::STATUS_SATURATED;
      end else begin
         status_in = tpi_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= div_done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         point_ff  <= point_in;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.point_x = point_ff[0];
   assign rsp_chan.point_y = point_ff[1];
   assign rsp_chan.point_z = point_ff[2];
   assign rsp_chan.status  = status_ff;

endmodule
